// File: src/spq_pkg.sv
// shared types and codes for the stable priority queue
// no dependencies; compile first

package spq_pkg;

    localparam int PRIO_W = 8;
    localparam int ID_W   = 16;
    localparam int TAG_W  = 16;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // request op codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // response status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef logic [2:0] cell_cmd_t;

    // per-cell commands
    localparam cell_cmd_t CMD_HOLD     = 3'd0;
    localparam cell_cmd_t CMD_CMP_GE   = 3'd1;
    localparam cell_cmd_t CMD_CMP_ID   = 3'd2;
    localparam cell_cmd_t CMD_CMP_HEAD = 3'd3;
    localparam cell_cmd_t CMD_INSERT   = 3'd4;
    localparam cell_cmd_t CMD_REMOVE   = 3'd5;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        cell_cmd_t         cmd;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   tid;
        entry_t            ent;
    } cell_ctl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   flag;
        entry_t ent;
    } cell_link_t;

endpackage

// File: src/spq_req_if.sv
// request channel of the stable priority queue
// depends on spq_pkg

interface spq_req_if import spq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   target_id;

    modport source (output valid, output op, output priority_req, output tag,
                    output target_id, input ready);
    modport sink (input valid, input op, input priority_req, input tag,
                  input target_id, output ready);
endinterface

// File: src/spq_rsp_if.sv
// response channel of the stable priority queue
// depends on spq_pkg

interface spq_rsp_if import spq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   entry_id;
    logic [PRIO_W-1:0] entry_priority;
    logic [TAG_W-1:0]  entry_tag;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, output status, output entry_id, output entry_priority,
                    output entry_tag, output occupancy, input ready);
    modport sink (input valid, input status, input entry_id, input entry_priority,
                  input entry_tag, input occupancy, output ready);
endinterface

// File: src/spq_cell.sv
// one slot of the sorted queue: holds an entry, compares it, shifts with neighbors
// depends on spq_pkg

module spq_cell import spq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic       head,
    input  cell_link_t left,
    input  cell_link_t right,
    input  logic       seen_in,
    output logic       seen_out,
    output cell_link_t self,
    output entry_t     taken
);

    logic   valid_reg;
    logic   valid_next;
    logic   flag_reg;
    logic   flag_next;
    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        valid_next = valid_reg;
        flag_next  = flag_reg;
        ent_next   = ent_reg;
        unique case (ctl.cmd)
            CMD_CMP_GE:
            begin
                flag_next = valid_reg && (ent_reg.prio >= ctl.prio);
            end
            CMD_CMP_ID:
            begin
                flag_next = valid_reg && (ent_reg.id == ctl.tid);
            end
            CMD_CMP_HEAD:
            begin
                flag_next = valid_reg && head;
            end
            CMD_INSERT:
            begin
                // keepers stay, the first non-keeper takes the new entry, the rest shift right
                if (!flag_reg)
                begin
                    ent_next = left.flag ? ctl.ent : left.ent;
                end
                valid_next = valid_reg | left.valid;
            end
            CMD_REMOVE:
            begin
                // the removed slot and all behind it pull from the right
                if (seen_in || flag_reg)
                begin
                    ent_next   = right.ent;
                    valid_next = right.valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign seen_out   = seen_in | flag_reg;
    assign self.valid = valid_reg;
    assign self.flag  = flag_reg;
    assign self.ent   = ent_reg;
    assign taken      = (flag_reg && !seen_in) ? ent_reg : '0;

endmodule

// File: src/stable_priority_queue_with_remove_top.sv
// top level of the stable priority queue with removal by id
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_cell

// Sorted queue of up to CAPACITY entries (priority, id, tag) held in a row of
// cells, highest priority at cell 0, equal priorities in arrival order. Each
// request passes through the states idle (accepted), eval (every cell compares
// its entry against the request at once) and apply (the row shifts by one
// place, right for insert, left for pop or remove, and the response is
// registered); apply waits while the response register is full and not being
// emptied. A new request is taken only once the last has been applied; the
// response is held in an output register, so the next request may be accepted
// while it waits. Insert assigns the next value of a wrapping 16-bit id
// counter; refused inserts (full) do not advance it. Op code 3 does nothing
// and returns ok. Occupancy is the count after the request, low five bits.

module stable_priority_queue_with_remove_top import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic        clk,
    input logic        rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;

    // captured request
    logic [OP_W-1:0]   op_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [ID_W-1:0]   tid_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [ID_W-1:0]   next_id_reg;
    logic [ID_W-1:0]   next_id_next;

    // response register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [STAT_W-1:0] out_status_reg;
    logic [STAT_W-1:0] out_status_next;
    entry_t            out_ent_reg;
    entry_t            out_ent_next;
    logic [CNT_W-1:0]  out_cnt_reg;

    // cell row wiring
    cell_ctl_t         ctl;
    cell_link_t        link [CAPACITY];
    logic [CAPACITY:0] seen;
    entry_t            taken [CAPACITY];
    entry_t            taken_any;
    logic [CAPACITY-1:0] valid_vec;

    logic              accept;
    logic              load_out;
    logic              full;
    logic              found;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign full     = (cnt_reg == CNT_W'(CAPACITY));
    assign found    = seen[CAPACITY];
    // the apply step waits until the response register is free or being emptied
    assign load_out = (state_reg == ST_APPLY) && (!out_valid_reg || rsp.ready);

    assign seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            cell_link_t left_in;
            cell_link_t right_in;

            if (gi == 0)
            begin : g_head
                // head sees an always-keeping neighbor so insert can land at slot 0
                assign left_in = '{valid: 1'b1, flag: 1'b1, ent: '0};
            end
            else
            begin : g_body
                assign left_in = link[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_in = '{valid: 1'b0, flag: 1'b0, ent: '0};
            end
            else
            begin : g_mid
                assign right_in = link[gi+1];
            end

            spq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .head     (gi == 0),
                .left     (left_in),
                .right    (right_in),
                .seen_in  (seen[gi]),
                .seen_out (seen[gi+1]),
                .self     (link[gi]),
                .taken    (taken[gi])
            );

            assign valid_vec[gi] = link[gi].valid;
        end
    endgenerate

    // at most one cell shows a nonzero taken entry
    always_comb
    begin
        taken_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            taken_any = taken_any | taken[i];
        end
    end

    // cell command for this cycle
    always_comb
    begin
        ctl.cmd      = CMD_HOLD;
        ctl.prio     = prio_reg;
        ctl.tid      = tid_reg;
        ctl.ent.prio = prio_reg;
        ctl.ent.id   = next_id_reg;
        ctl.ent.tag  = tag_reg;
        if (state_reg == ST_EVAL)
        begin
            unique case (op_reg)
                OP_INSERT: ctl.cmd = CMD_CMP_GE;
                OP_POP:    ctl.cmd = CMD_CMP_HEAD;
                OP_REMOVE: ctl.cmd = CMD_CMP_ID;
                default:   ctl.cmd = CMD_HOLD;
            endcase
        end
        else if (load_out)
        begin
            unique case (op_reg)
                OP_INSERT: ctl.cmd = full ? CMD_HOLD : CMD_INSERT;
                OP_POP,
                OP_REMOVE: ctl.cmd = found ? CMD_REMOVE : CMD_HOLD;
                default:   ctl.cmd = CMD_HOLD;
            endcase
        end
    end

    // sequencer, counters and response
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        next_id_next    = next_id_reg;
        out_status_next = out_status_reg;
        out_ent_next    = out_ent_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (load_out)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_ent_next    = '0;
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                out_ent_next.id = next_id_reg;
                                next_id_next    = next_id_reg + 1'b1;
                                cnt_next        = cnt_reg + 1'b1;
                            end
                        end
                        OP_POP,
                        OP_REMOVE:
                        begin
                            if (found)
                            begin
                                out_ent_next = taken_any;
                                cnt_next     = cnt_reg - 1'b1;
                            end
                            else
                            begin
                                out_status_next = STAT_MISS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request capture and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            prio_reg <= req.priority_req;
            tag_reg  <= req.tag;
            tid_reg  <= req.target_id;
        end
        if (load_out)
        begin
            out_cnt_reg <= cnt_next;
        end
        out_status_reg <= out_status_next;
        out_ent_reg    <= out_ent_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.entry_id       = out_ent_reg.id;
    assign rsp.entry_priority = out_ent_reg.prio;
    assign rsp.entry_tag      = out_ent_reg.tag;
    assign rsp.occupancy      = OCC_W'(out_cnt_reg);

    // occupied slots always form a prefix starting at slot 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("occupied slots are not a prefix");

    // entry counter tracks the occupied slots
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(cnt_reg))
        else $error("entry count disagrees with occupied slots");

    // a pending response reports the current count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (out_cnt_reg == cnt_reg))
        else $error("response occupancy is stale");

    // a full status is only given when every slot is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STAT_FULL)) |-> full)
        else $error("full status with free slots");

endmodule

// File: bench/stable_priority_queue_with_remove_top_tb.sv
// self-checking testbench for stable_priority_queue_with_remove_top
// depends on spq_pkg, spq_req_if, spq_rsp_if and the queue rtl

`timescale 1ns / 100ps

module stable_priority_queue_with_remove_top_tb;
    import spq_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no request or response accepted
    localparam int STALL_CYCLES   = 300;    // long receiver hold-off

    // op code 3 has no name in the package: it is a no-op
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    // one response, in the order the fields appear on the channel
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic [OCC_W-1:0]  occ;
    } spq_result_t;

    logic clk;
    logic rst_n;

    spq_req_if req ();
    spq_rsp_if rsp ();

    stable_priority_queue_with_remove_top #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // mirror of the queue contents, slot 0 is the head
    logic [PRIO_W-1:0] held_prio [CAPACITY];
    logic [ID_W-1:0]   held_id   [CAPACITY];
    logic [TAG_W-1:0]  held_tag  [CAPACITY];
    int                held_count;
    logic [ID_W-1:0]   next_free_id;

    // responses still owed by the queue, oldest first
    spq_result_t pending_results [$];

    int errors;
    int tx_idle_pct;
    int rx_idle_pct;
    int stall_left;
    int quiet_cycles;

    // clock, 4 ns period
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // close the gap left at slot pos
    function automatic void drop_slot(input int pos);
        int i;
        for (i = pos; i + 1 < held_count; i++)
        begin
            held_prio[i] = held_prio[i + 1];
            held_id[i]   = held_id[i + 1];
            held_tag[i]  = held_tag[i + 1];
        end
        held_count--;
    endfunction

    // update the mirror with one accepted request and return the response it owes
    function automatic spq_result_t apply_request(input logic [OP_W-1:0]   op,
                                                  input logic [PRIO_W-1:0] prio,
                                                  input logic [TAG_W-1:0]  tag,
                                                  input logic [ID_W-1:0]   tid);
        spq_result_t r;
        int          pos;
        int          i;
        r = '0;
        case (op)
            OP_INSERT:
            begin
                if (held_count >= CAPACITY)
                begin
                    // refused, id counter stays put
                    r.status = STAT_FULL;
                end
                else
                begin
                    // goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < held_count && held_prio[pos] >= prio)
                        pos++;
                    for (i = held_count; i > pos; i--)
                    begin
                        held_prio[i] = held_prio[i - 1];
                        held_id[i]   = held_id[i - 1];
                        held_tag[i]  = held_tag[i - 1];
                    end
                    held_prio[pos] = prio;
                    held_id[pos]   = next_free_id;
                    held_tag[pos]  = tag;
                    held_count++;
                    r.id         = next_free_id;
                    next_free_id = next_free_id + 1'b1;
                end
            end
            OP_POP:
            begin
                if (held_count == 0)
                begin
                    r.status = STAT_MISS;
                end
                else
                begin
                    r.id   = held_id[0];
                    r.prio = held_prio[0];
                    r.tag  = held_tag[0];
                    drop_slot(0);
                end
            end
            OP_REMOVE:
            begin
                // first match in queue order wins, which matters once ids repeat
                pos = 0;
                while (pos < held_count && held_id[pos] != tid)
                    pos++;
                if (pos >= held_count)
                begin
                    r.status = STAT_MISS;
                end
                else
                begin
                    r.id   = held_id[pos];
                    r.prio = held_prio[pos];
                    r.tag  = held_tag[pos];
                    drop_slot(pos);
                end
            end
            default:
            begin
                // no-op: status ok, occupancy unchanged
            end
        endcase
        r.occ = held_count[OCC_W-1:0];
        return r;
    endfunction

    // offer one request, driven at the falling edge, and predict it once taken
    task automatic send_request(input logic [OP_W-1:0]   op,
                                input logic [PRIO_W-1:0] prio,
                                input logic [TAG_W-1:0]  tag,
                                input logic [ID_W-1:0]   tid);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
        end
        @(negedge clk);
        req.valid        <= 1'b1;
        req.op           <= op;
        req.priority_req <= prio;
        req.tag          <= tag;
        req.target_id    <= tid;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        pending_results.push_back(apply_request(op, prio, tag, tid));
    endtask

    // drop valid once nothing follows right away
    task automatic release_request();
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    // idle settings change at the rising edge so the receiver sees them cleanly
    task automatic set_idling(input int tx_pct, input int rx_pct);
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // pop, remove and the no-op against an empty queue
    task automatic test_empty_queue();
        send_request(OP_POP, 8'h00, 16'h0000, 16'h0000);
        send_request(OP_REMOVE, 8'hff, 16'hffff, 16'h0000);
        send_request(OP_NOP, 8'h5a, 16'ha5a5, 16'hffff);
        release_request();
    endtask

    // fill to capacity with ties and the priority extremes, then hit the full case
    task automatic test_fill_to_capacity();
        logic [PRIO_W-1:0] prios [CAPACITY];
        int k;
        prios = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd255, 8'd7, 8'd0, 8'd200,
                  8'd128, 8'd1, 8'd254, 8'd64, 8'd255, 8'd0, 8'd127, 8'd128};
        for (k = 0; k < CAPACITY; k++)
            send_request(OP_INSERT, prios[k], (k % 2 == 0) ? 16'h0000 : 16'hffff,
                         ID_W'($urandom_range(65535)));
        send_request(OP_INSERT, 8'hff, 16'hbeef, 16'h0000);
        send_request(OP_NOP, 8'h00, 16'h0000, 16'h0000);
        release_request();
    endtask

    // remove from the middle and the tail, and an id that is not there, then pop the head
    task automatic test_remove_by_id();
        send_request(OP_REMOVE, 8'h00, 16'h0000, held_id[5]);
        send_request(OP_REMOVE, 8'hff, 16'hffff, held_id[held_count - 1]);
        send_request(OP_REMOVE, 8'h00, 16'h0000, 16'hffff);
        send_request(OP_POP, 8'hff, 16'hffff, 16'hffff);
        release_request();
    endtask

    // receiver holds off for a long stretch while requests keep coming,
    // so the response register fills and the queue stops taking requests
    task automatic test_output_backpressure();
        int k;
        int pops;
        set_idling(0, 0);
        stall_left = STALL_CYCLES;
        for (k = 0; k < 6; k++)
            send_request(OP_INSERT, PRIO_W'($urandom_range(255)),
                         TAG_W'($urandom_range(65535)), ID_W'($urandom_range(65535)));
        pops = held_count + 1;
        for (k = 0; k < pops; k++)
            send_request(OP_POP, PRIO_W'($urandom_range(255)),
                         TAG_W'($urandom_range(65535)), ID_W'($urandom_range(65535)));
        release_request();
    endtask

    // mixed traffic; the insert share swings so the queue keeps filling and draining
    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int                k;
        int                pick;
        int                fill_bias;
        logic [OP_W-1:0]   op;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   tid;
        set_idling(tx_pct, rx_pct);
        fill_bias = 50;
        for (k = 0; k < n_items; k++)
        begin
            if (k % 60 == 0)
                fill_bias = ($urandom_range(1) == 1) ? 75 : 30;
            pick = $urandom_range(99);
            // small priorities make ties common, the rest spans the full range
            prio = ($urandom_range(3) == 0) ? PRIO_W'($urandom_range(255))
                                            : PRIO_W'($urandom_range(3));
            tid  = ID_W'($urandom_range(65535));
            if (pick < fill_bias)
                op = OP_INSERT;
            else if (pick < fill_bias + (94 - fill_bias) / 2)
                op = OP_POP;
            else if (pick < 94)
            begin
                op = OP_REMOVE;
                // mostly ids that are held, sometimes a likely miss
                if (held_count > 0 && $urandom_range(3) != 0)
                    tid = held_id[$urandom_range(held_count - 1)];
            end
            else
                op = OP_NOP;
            send_request(op, prio, TAG_W'($urandom_range(65535)), tid);
        end
        release_request();
    endtask

    // receiver: random ready at the falling edge, or held low during a stall
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // response checker, sampled at the rising edge
    always @(posedge clk)
    begin : check_responses
        spq_result_t got;
        spq_result_t want;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            got = '{rsp.status, rsp.entry_id, rsp.entry_priority, rsp.entry_tag,
                    rsp.occupancy};
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response status=%0d id=%h prio=%h tag=%h occ=%0d",
                         $time, got.status, got.id, got.prio, got.tag, got.occ);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    // fields: status/id/prio/tag/occupancy
                    $display("%0t: mismatch expected %0d/%h/%h/%h/%0d actual %0d/%h/%h/%h/%0d",
                             $time, want.status, want.id, want.prio, want.tag, want.occ,
                             got.status, got.id, got.prio, got.tag, got.occ);
                end
            end
        end
    end

    // watchdog: ends the run after too long with no request or response taken
    always @(posedge clk)
    begin
        if ((req.valid === 1'b1 && req.ready === 1'b1) ||
            (rsp.valid === 1'b1 && rsp.ready === 1'b1) || rst_n !== 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        errors           = 0;
        stall_left       = 0;
        tx_idle_pct      = 19;
        rx_idle_pct      = 85;
        held_count       = 0;
        next_free_id     = '0;
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.op           = OP_INSERT;
        req.priority_req = '0;
        req.tag          = '0;
        req.target_id    = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed requests under the first idling mix
        test_empty_queue();
        test_fill_to_capacity();
        test_remove_by_id();

        // random traffic: sender light / receiver heavy, then swapped, then none
        test_random_traffic(400, 19, 85);
        test_random_traffic(400, 85, 19);
        test_random_traffic(400, 0, 0);

        test_output_backpressure();

        // let every owed response come back, then a few quiet cycles
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
